// ===== sv/mavg_pkg.sv =====
// Shared constants, types and codes for the moving average to PWM duty block.
// No dependencies; every other file in this folder imports this package.
package mavg_pkg;

    // Window length and field widths.
    localparam int WINDOW_LEN  = 16;
    localparam int SAMPLE_W    = 12;
    localparam int AVG_W       = 12;
    localparam int PWM_W       = 16;
    localparam int VREF_W      = 13;
    localparam int DUTY_W      = 16;
    localparam int MV_W        = 13;
    localparam int FULL_SCALE  = 4095;

    // Ring bookkeeping widths.
    localparam int SUM_W  = $clog2(WINDOW_LEN * FULL_SCALE + 1);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

    // Product lanes and the divide by full scale.
    localparam int PROD_W      = AVG_W + PWM_W;
    localparam int SCALE_Q_W   = 16;
    localparam int SCALE_REM_W = PROD_W - SCALE_Q_W;

    // Iteration counts of the two serial dividers.
    localparam int AVG_STEPS   = SUM_W;
    localparam int SCALE_STEPS = SCALE_Q_W;
    localparam int MAX_STEPS   = (AVG_STEPS > SCALE_STEPS) ? AVG_STEPS : SCALE_STEPS;
    localparam int CNT_W       = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [PWM_W-1:0]  PWM_PERIOD_RESET = PWM_W'(1000);
    localparam logic [VREF_W-1:0] VREF_MV_RESET    = VREF_W'(3300);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD = 1'b0,
        REG_VREF_MV    = 1'b1
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_AVG_LOAD,
        ST_AVG,
        ST_SCALE_LOAD,
        ST_SCALE,
        ST_OUT
    } seq_state_t;

    // Control of the sample ring.
    typedef struct packed {
        logic capture;
        logic update;
    } ring_ctrl_t;

    // Control of a serial divider.
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

// ===== sv/moving_average_to_pwm_duty.sv =====
// Boxcar moving average of 12-bit converter samples over the last 16, scaled
// to a PWM compare value and a millivolt estimate. One sample is taken per
// transaction and gives one result. Each item passes through these steps in
// order, starting with the cycle in which it is accepted: that cycle captures
// the sample, the update state writes the ring and running sum, then a
// bit-serial divide of the sum by the fill count (one load and 16 steps, with
// the two scaling products built alongside) and a bit-serial divide of both
// products by 4095 (one load and 16 steps), and last the result register is
// loaded once the result channel is free. A new sample is accepted in the
// cycle after the previous result has been loaded, so a new item is not taken
// while the previous one is still in progress.
// Configuration writes are always accepted and must only be made while idle.
// Depends on mavg_pkg, mavg_ring, mavg_avg_div and mavg_scale_div.
module moving_average_to_pwm_duty
    import mavg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // Sample channel
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  logic [SAMPLE_W-1:0]   sample,
    // Result channel
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [AVG_W-1:0]      average,
    output logic [DUTY_W-1:0]     duty_counts,
    output logic [MV_W-1:0]       millivolts
);

    seq_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [PWM_W-1:0]    pwm_period_reg;
    logic [VREF_W-1:0]   vref_mv_reg;
    logic                result_valid_reg, result_valid_next;
    logic [AVG_W-1:0]    average_reg;
    logic [DUTY_W-1:0]   duty_reg;
    logic [MV_W-1:0]     mv_reg;
    logic                sample_xact;
    logic                out_free;
    logic                out_load;
    ring_ctrl_t          ring_ctrl;
    div_ctrl_t           avg_ctrl;
    div_ctrl_t           scale_ctrl;
    logic [SUM_W-1:0]    ring_sum;
    logic [FILL_W-1:0]   ring_fill;
    logic [AVG_W-1:0]    avg_q;
    logic [PROD_W-1:0]   prod_duty;
    logic [PROD_W-1:0]   prod_mv;
    logic [SCALE_Q_W-1:0] duty_q;
    logic [SCALE_Q_W-1:0] mv_q;

    // Configuration registers; writes never stall.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pwm_period_reg <= PWM_PERIOD_RESET;
            vref_mv_reg    <= VREF_MV_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PWM_PERIOD: pwm_period_reg <= cfg_data[PWM_W-1:0];
                REG_VREF_MV:    vref_mv_reg    <= cfg_data[VREF_W-1:0];
                default:        ;
            endcase
        end
    end

    assign sample_xact = sample_valid && sample_ready;
    assign out_free    = !result_valid_reg || result_ready;

    // Sequencer next state and iteration count.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_AVG_LOAD;
            end
            ST_AVG_LOAD:
            begin
                cnt_next   = '0;
                state_next = ST_AVG;
            end
            ST_AVG:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(AVG_STEPS - 1))
                begin
                    state_next = ST_SCALE_LOAD;
                end
            end
            ST_SCALE_LOAD:
            begin
                cnt_next   = '0;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SCALE_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        sample_ready      = 1'b0;
        ring_ctrl         = '0;
        avg_ctrl          = '0;
        scale_ctrl        = '0;
        out_load          = 1'b0;
        unique case (state_reg)
            ST_IDLE:       sample_ready     = 1'b1;
            ST_UPDATE:     ring_ctrl.update = 1'b1;
            ST_AVG_LOAD:   avg_ctrl.load    = 1'b1;
            ST_AVG:        avg_ctrl.step    = 1'b1;
            ST_SCALE_LOAD: scale_ctrl.load  = 1'b1;
            ST_SCALE:      scale_ctrl.step  = 1'b1;
            ST_OUT:        out_load         = out_free;
            default:       ;
        endcase
        ring_ctrl.capture = sample_xact;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Datapath.
    mavg_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ring_ctrl),
        .sample (sample),
        .sum    (ring_sum),
        .fill   (ring_fill)
    );

    mavg_avg_div u_avg_div (
        .clk        (clk),
        .ctrl       (avg_ctrl),
        .sum        (ring_sum),
        .fill       (ring_fill),
        .pwm_period (pwm_period_reg),
        .vref_mv    (vref_mv_reg),
        .average    (avg_q),
        .prod_duty  (prod_duty),
        .prod_mv    (prod_mv)
    );

    mavg_scale_div u_duty_div (
        .clk      (clk),
        .ctrl     (scale_ctrl),
        .prod     (prod_duty),
        .quotient (duty_q)
    );

    mavg_scale_div u_mv_div (
        .clk      (clk),
        .ctrl     (scale_ctrl),
        .prod     (prod_mv),
        .quotient (mv_q)
    );

    // Result register.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            average_reg <= avg_q;
            duty_reg    <= duty_q[DUTY_W-1:0];
            mv_reg      <= mv_q[MV_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign average      = average_reg;
    assign duty_counts  = duty_reg;
    assign millivolts   = mv_reg;

endmodule

// ===== sv/mavg_ring.sv =====
// Sample ring with running sum, fill count and write position.
// Depends on mavg_pkg.
module mavg_ring
    import mavg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ring_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] sample,
    output logic [SUM_W-1:0]    sum,
    output logic [FILL_W-1:0]   fill
);

    logic [SAMPLE_W-1:0] ring_mem [WINDOW_LEN];
    logic [SAMPLE_W-1:0] old_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]    pos_reg,  pos_next;
    logic [SUM_W-1:0]    sum_reg,  sum_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                full;

    // Capture the new sample and read the slot it will overwrite.
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            old_reg    <= ring_mem[pos_reg];
            sample_reg <= sample;
        end
        if (ctrl.update)
        begin
            ring_mem[pos_reg] <= sample_reg;
        end
    end

    // Next sum, fill count and position.
    always_comb
    begin
        full      = (fill_reg == FILL_W'(WINDOW_LEN));
        sum_next  = sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(sample_reg);
        fill_next = full ? fill_reg : fill_reg + FILL_W'(1);
        if (pos_reg == POS_W'(WINDOW_LEN - 1))
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            sum_reg  <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.update)
        begin
            pos_reg  <= pos_next;
            sum_reg  <= sum_next;
            fill_reg <= fill_next;
        end
    end

    assign sum  = sum_reg;
    assign fill = fill_reg;

`ifndef SYNTHESIS
    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(WINDOW_LEN))
        else $error("Fill count exceeds the window length.");

    a_sum_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sum_reg) <= 32'(fill_reg) * 32'(FULL_SCALE))
        else $error("Running sum exceeds the stored samples at full scale.");

    a_pos_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg < FILL_W'(WINDOW_LEN)) |-> (pos_reg == POS_W'(fill_reg)))
        else $error("Write position out of step with the fill count while filling.");

    a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.update && (fill_reg < FILL_W'(WINDOW_LEN)))
        |=> (fill_reg == $past(fill_reg) + FILL_W'(1)))
        else $error("Fill count did not advance on a transaction while filling.");
`endif

endmodule

// ===== sv/mavg_avg_div.sv =====
// Bit-serial divide of the running sum by the fill count; each quotient bit
// also drives two shift-and-add multipliers by the PWM period and reference.
// Depends on mavg_pkg.
module mavg_avg_div
    import mavg_pkg::*;
(
    input  logic              clk,
    input  div_ctrl_t         ctrl,
    input  logic [SUM_W-1:0]  sum,
    input  logic [FILL_W-1:0] fill,
    input  logic [PWM_W-1:0]  pwm_period,
    input  logic [VREF_W-1:0] vref_mv,
    output logic [AVG_W-1:0]  average,
    output logic [PROD_W-1:0] prod_duty,
    output logic [PROD_W-1:0] prod_mv
);

    logic [SUM_W-1:0]  dvd_reg;
    logic [FILL_W-1:0] rem_reg,   rem_next;
    logic [FILL_W-1:0] div_reg;
    logic [AVG_W-1:0]  quo_reg;
    logic [PROD_W-1:0] duty_reg,  duty_next;
    logic [PROD_W-1:0] mv_reg,    mv_next;
    logic [FILL_W:0]   trial;
    logic              q_bit;

    // One restoring step; the quotient bit, most significant first,
    // doubles and conditionally adds into both product lanes.
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[SUM_W-1]};
        q_bit     = (trial >= {1'b0, div_reg});
        rem_next  = q_bit ? FILL_W'(trial - {1'b0, div_reg}) : FILL_W'(trial);
        duty_next = PROD_W'({duty_reg, 1'b0}) + (q_bit ? PROD_W'(pwm_period) : '0);
        mv_next   = PROD_W'({mv_reg, 1'b0}) + (q_bit ? PROD_W'(vref_mv) : '0);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            dvd_reg  <= sum;
            div_reg  <= fill;
            rem_reg  <= '0;
            quo_reg  <= '0;
            duty_reg <= '0;
            mv_reg   <= '0;
        end
        else if (ctrl.step)
        begin
            dvd_reg  <= {dvd_reg[SUM_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[AVG_W-2:0], q_bit};
            duty_reg <= duty_next;
            mv_reg   <= mv_next;
        end
    end

    assign average   = quo_reg;
    assign prod_duty = duty_reg;
    assign prod_mv   = mv_reg;

endmodule

// ===== sv/mavg_scale_div.sv =====
// Bit-serial divide of one product lane by the converter full scale.
// Depends on mavg_pkg.
module mavg_scale_div
    import mavg_pkg::*;
(
    input  logic                 clk,
    input  div_ctrl_t            ctrl,
    input  logic [PROD_W-1:0]    prod,
    output logic [SCALE_Q_W-1:0] quotient
);

    logic [SCALE_Q_W-1:0]   dvd_reg;
    logic [SCALE_REM_W-1:0] rem_reg, rem_next;
    logic [SCALE_Q_W-1:0]   quo_reg;
    logic [SCALE_REM_W:0]   trial;
    logic                   q_bit;

    // The upper bits start as the partial remainder: the quotient is known
    // to fit in the lower bits, so that part is already below full scale.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[SCALE_Q_W-1]};
        q_bit    = (trial >= (SCALE_REM_W+1)'(FULL_SCALE));
        rem_next = q_bit ? SCALE_REM_W'(trial - (SCALE_REM_W+1)'(FULL_SCALE))
                         : SCALE_REM_W'(trial);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= prod[PROD_W-1:SCALE_Q_W];
            dvd_reg <= prod[SCALE_Q_W-1:0];
            quo_reg <= '0;
        end
        else if (ctrl.step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[SCALE_Q_W-2:0], 1'b0};
            quo_reg <= {quo_reg[SCALE_Q_W-2:0], q_bit};
        end
    end

    assign quotient = quo_reg;

endmodule
